### design/cpu8eu_pkg.sv
// shared types and constants for the cpu8 execute unit
// instruction classes, register file and branch result structs, status bit positions
// no dependencies
package cpu8eu_pkg;

   // status byte bit positions
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   // branch opcode bits 7..6 pick the tested flag
   localparam logic [1:0] BR_SEL_N = 2'd0;
   localparam logic [1:0] BR_SEL_V = 2'd1;
   localparam logic [1:0] BR_SEL_C = 2'd2;
   localparam logic [1:0] BR_SEL_Z = 2'd3;

   typedef enum logic [4:0] {
      OP_ADC,
      OP_ORA,
      OP_LDA,
      OP_LDX,
      OP_LDY,
      OP_CMP,
      OP_CPX,
      OP_CPY,
      OP_INX,
      OP_INY,
      OP_DEX,
      OP_DEY,
      OP_TAX,
      OP_TAY,
      OP_TXA,
      OP_TYA,
      OP_TXS,
      OP_CLD,
      OP_NOP,
      OP_BRANCH,
      OP_BAD
   } op_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] status;
   } regs_type;

   typedef struct packed {
      logic        taken;
      logic [15:0] next_pc;
      logic        crossed;
   } branch_type;

endpackage

### design/cpu8eu_decode.sv
// opcode decoder for the cpu8 execute unit
// maps the opcode byte to an instruction class; uses cpu8eu_pkg
module cpu8eu_decode
   import cpu8eu_pkg::*;
(
   input  logic [7:0] opcode,
   output op_type     op_class
);

   always_comb begin
      unique case (opcode) inside
         8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: op_class = OP_ADC;
         8'h01, 8'h05, 8'h0D, 8'h11, 8'h15, 8'h19, 8'h1D:        op_class = OP_ORA;
         8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: op_class = OP_LDA;
         8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE:                      op_class = OP_LDX;
         8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC:                      op_class = OP_LDY;
         8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: op_class = OP_CMP;
         8'hE0, 8'hE4, 8'hEC:                                    op_class = OP_CPX;
         8'hC0, 8'hC4, 8'hCC:                                    op_class = OP_CPY;
         8'hE8: op_class = OP_INX;
         8'hC8: op_class = OP_INY;
         8'hCA: op_class = OP_DEX;
         8'h88: op_class = OP_DEY;
         8'hAA: op_class = OP_TAX;
         8'hA8: op_class = OP_TAY;
         8'h8A: op_class = OP_TXA;
         8'h98: op_class = OP_TYA;
         8'h9A: op_class = OP_TXS;
         8'hD8: op_class = OP_CLD;
         8'hEA: op_class = OP_NOP;
         8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: op_class = OP_BRANCH;
         default: op_class = OP_BAD;
      endcase
   end

endmodule

### design/cpu8eu_alu.sv
// datapath of the cpu8 execute unit: register file update, flags and branch target
// purely combinational; uses cpu8eu_pkg
module cpu8eu_alu
   import cpu8eu_pkg::*;
(
   input  op_type      op_class,
   input  logic [7:0]  opcode,
   input  logic [7:0]  operand_byte,
   input  logic [15:0] pc_next,
   input  regs_type    regs_cur,
   output regs_type    regs_nxt,
   output branch_type  branch
);

   logic [8:0]  sum9;
   logic [7:0]  adc_res;
   logic [7:0]  cmp_reg;
   logic [8:0]  diff9;
   logic [7:0]  zn_val;
   logic        zn_en;
   logic        flag_have;
   logic [15:0] offset;
   logic [15:0] target;

   always_comb begin
      sum9    = {1'b0, regs_cur.acc} + {1'b0, operand_byte}
              + {8'd0, regs_cur.status[FLAG_C]};
      adc_res = sum9[7:0];

      case (op_class)
         OP_CPX:  cmp_reg = regs_cur.x;
         OP_CPY:  cmp_reg = regs_cur.y;
         default: cmp_reg = regs_cur.acc;
      endcase
      diff9 = {1'b0, cmp_reg} - {1'b0, operand_byte};

      case (opcode[7:6])
         BR_SEL_N: flag_have = regs_cur.status[FLAG_N];
         BR_SEL_V: flag_have = regs_cur.status[FLAG_V];
         BR_SEL_C: flag_have = regs_cur.status[FLAG_C];
         BR_SEL_Z: flag_have = regs_cur.status[FLAG_Z];
         default:  flag_have = 1'b0;
      endcase
      offset = {{8{operand_byte[7]}}, operand_byte};
      target = pc_next + offset;
   end

   always_comb begin
      regs_nxt       = regs_cur;
      zn_val         = 8'd0;
      zn_en          = 1'b0;
      branch.taken   = 1'b0;
      branch.next_pc = pc_next;
      branch.crossed = 1'b0;

      case (op_class)
         OP_ADC: begin
            regs_nxt.acc            = adc_res;
            regs_nxt.status[FLAG_C] = sum9[8];
            regs_nxt.status[FLAG_V] = ~(regs_cur.acc[7] ^ operand_byte[7])
                                      & (regs_cur.acc[7] ^ adc_res[7]);
            zn_val = adc_res;
            zn_en  = 1'b1;
         end
         OP_ORA: begin
            regs_nxt.acc = regs_cur.acc | operand_byte;
            zn_val = regs_cur.acc | operand_byte;
            zn_en  = 1'b1;
         end
         OP_LDA: begin
            regs_nxt.acc = operand_byte;
            zn_val = operand_byte;
            zn_en  = 1'b1;
         end
         OP_LDX: begin
            regs_nxt.x = operand_byte;
            zn_val = operand_byte;
            zn_en  = 1'b1;
         end
         OP_LDY: begin
            regs_nxt.y = operand_byte;
            zn_val = operand_byte;
            zn_en  = 1'b1;
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            // carry means no borrow, the register itself is untouched
            regs_nxt.status[FLAG_C] = ~diff9[8];
            zn_val = diff9[7:0];
            zn_en  = 1'b1;
         end
         OP_INX: begin
            regs_nxt.x = regs_cur.x + 8'd1;
            zn_val = regs_cur.x + 8'd1;
            zn_en  = 1'b1;
         end
         OP_INY: begin
            regs_nxt.y = regs_cur.y + 8'd1;
            zn_val = regs_cur.y + 8'd1;
            zn_en  = 1'b1;
         end
         OP_DEX: begin
            regs_nxt.x = regs_cur.x - 8'd1;
            zn_val = regs_cur.x - 8'd1;
            zn_en  = 1'b1;
         end
         OP_DEY: begin
            regs_nxt.y = regs_cur.y - 8'd1;
            zn_val = regs_cur.y - 8'd1;
            zn_en  = 1'b1;
         end
         OP_TAX: begin
            regs_nxt.x = regs_cur.acc;
            zn_val = regs_cur.acc;
            zn_en  = 1'b1;
         end
         OP_TAY: begin
            regs_nxt.y = regs_cur.acc;
            zn_val = regs_cur.acc;
            zn_en  = 1'b1;
         end
         OP_TXA: begin
            regs_nxt.acc = regs_cur.x;
            zn_val = regs_cur.x;
            zn_en  = 1'b1;
         end
         OP_TYA: begin
            regs_nxt.acc = regs_cur.y;
            zn_val = regs_cur.y;
            zn_en  = 1'b1;
         end
         OP_TXS: begin
            regs_nxt.sp = regs_cur.x;
         end
         OP_CLD: begin
            regs_nxt.status[FLAG_D] = 1'b0;
         end
         OP_BRANCH: begin
            // opcode bit 5 is the flag value that takes the branch
            if (flag_have == opcode[5]) begin
               branch.taken   = 1'b1;
               branch.next_pc = target;
               branch.crossed = target[15:8] != pc_next[15:8];
            end
         end
         default: begin
         end
      endcase

      if (zn_en) begin
         regs_nxt.status[FLAG_Z] = zn_val == 8'd0;
         regs_nxt.status[FLAG_N] = zn_val[7];
      end
   end

endmodule

### design/cpu8_execute_unit.sv
// top level of the cpu8 execute unit: input register, register file and result register
// uses cpu8eu_pkg, cpu8eu_decode and cpu8eu_alu
//
// usage
//   req channel: one instruction per transfer (opcode, operand byte already
//   fetched, address of the following instruction)
//   rsp channel: one result per instruction (A, X, Y, SP, status after it,
//   branch taken, next pc, page-cross mark, unsupported-opcode flag)
//   order: a req transfer lands in the input register; when the item moves
//   on, its result is registered into the result register and rsp_valid rises
//   throughput: one instruction per cycle while rsp_ready is high; the
//   register file is updated as an item moves from input to result register,
//   so the next one sees it with no bubble (8-bit adder and compare feedback)
//   stall: while rsp_ready is low the result register holds; the input
//   register still takes one more instruction, then req_ready drops
//   reset: clears A, X, Y, SP, status and both valid bits
//   an unsupported opcode still gives a result, with the register file untouched
module cpu8_execute_unit
   import cpu8eu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_operand_byte,
   input  logic [15:0] req_pc_next,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_acc_value,
   output logic [7:0]  rsp_x_value,
   output logic [7:0]  rsp_y_value,
   output logic [7:0]  rsp_sp_value,
   output logic [7:0]  rsp_status_value,
   output logic        rsp_branch_taken,
   output logic [15:0] rsp_next_pc,
   output logic        rsp_page_crossed,
   output logic        rsp_unsupported
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_opcode_ff;
   logic [7:0]  in_operand_ff;
   logic [15:0] in_pc_ff;

   // architectural registers
   regs_type    regs_ff, regs_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   regs_type    out_regs_ff;
   branch_type  out_branch_ff;
   logic        out_bad_ff;

   op_type      op_class;
   branch_type  branch;
   logic        req_xfer;
   logic        advance;

   // an item moves on when the result register is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   cpu8eu_decode u_decode (
      .opcode   (in_opcode_ff),
      .op_class (op_class)
   );

   cpu8eu_alu u_alu (
      .op_class     (op_class),
      .opcode       (in_opcode_ff),
      .operand_byte (in_operand_ff),
      .pc_next      (in_pc_ff),
      .regs_cur     (regs_ff),
      .regs_nxt     (regs_in),
      .branch       (branch)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control state and register file
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         regs_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            regs_ff <= regs_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_opcode_ff  <= req_opcode;
         in_operand_ff <= req_operand_byte;
         in_pc_ff      <= req_pc_next;
      end
      if (advance) begin
         out_regs_ff   <= regs_in;
         out_branch_ff <= branch;
         out_bad_ff    <= op_class == OP_BAD;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_acc_value    = out_regs_ff.acc;
   assign rsp_x_value      = out_regs_ff.x;
   assign rsp_y_value      = out_regs_ff.y;
   assign rsp_sp_value     = out_regs_ff.sp;
   assign rsp_status_value = out_regs_ff.status;
   assign rsp_branch_taken = out_branch_ff.taken;
   assign rsp_next_pc      = out_branch_ff.next_pc;
   assign rsp_page_crossed = out_branch_ff.crossed;
   assign rsp_unsupported  = out_bad_ff;

   // an unsupported opcode leaves the register file as it was
   a_bad_keeps_regs: assert property (@(posedge clock) disable iff (reset)
      advance && op_class == OP_BAD |=> regs_ff == $past(regs_ff))
      else $error("unsupported opcode changed the register file");

   // a pending result always shows the current register file
   a_rsp_matches_regs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_regs_ff == regs_ff)
      else $error("result register out of step with register file");

   // a page cross only comes with a taken branch
   a_cross_needs_taken: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_crossed |-> rsp_branch_taken)
      else $error("page cross without taken branch");

   // status bits 2, 4 and 5 are never written
   a_unused_status: assert property (@(posedge clock) disable iff (reset)
      regs_ff.status[2] == 1'b0 && regs_ff.status[5:4] == 2'b00)
      else $error("unused status bit set");

endmodule

### bench/cpu8eu_check_pkg.sv
// opcode names, instruction decode and the result scoreboard for the execute unit bench
// the scoreboard keeps its own register file and predicts one result per instruction
// depends on cpu8eu_pkg for op_type, regs_type and the status bit positions
package cpu8eu_check_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import cpu8eu_pkg::*;

   localparam logic [7:0] OPC_ADC_IMM = 8'h69, OPC_ADC_ZP  = 8'h65, OPC_ADC_ZPX = 8'h75;
   localparam logic [7:0] OPC_ADC_ABS = 8'h6D, OPC_ADC_ABX = 8'h7D, OPC_ADC_ABY = 8'h79;
   localparam logic [7:0] OPC_ADC_IZX = 8'h61, OPC_ADC_IZY = 8'h71;
   localparam logic [7:0] OPC_ORA_IZX = 8'h01, OPC_ORA_ZP  = 8'h05, OPC_ORA_ABS = 8'h0D;
   localparam logic [7:0] OPC_ORA_IZY = 8'h11, OPC_ORA_ZPX = 8'h15, OPC_ORA_ABY = 8'h19;
   localparam logic [7:0] OPC_ORA_ABX = 8'h1D;
   localparam logic [7:0] OPC_LDA_IMM = 8'hA9, OPC_LDA_ZP  = 8'hA5, OPC_LDA_ZPX = 8'hB5;
   localparam logic [7:0] OPC_LDA_ABS = 8'hAD, OPC_LDA_ABX = 8'hBD, OPC_LDA_ABY = 8'hB9;
   localparam logic [7:0] OPC_LDA_IZX = 8'hA1, OPC_LDA_IZY = 8'hB1;
   localparam logic [7:0] OPC_LDX_IMM = 8'hA2, OPC_LDX_ZP  = 8'hA6, OPC_LDX_ZPY = 8'hB6;
   localparam logic [7:0] OPC_LDX_ABS = 8'hAE, OPC_LDX_ABY = 8'hBE;
   localparam logic [7:0] OPC_LDY_IMM = 8'hA0, OPC_LDY_ZP  = 8'hA4, OPC_LDY_ZPX = 8'hB4;
   localparam logic [7:0] OPC_LDY_ABS = 8'hAC, OPC_LDY_ABX = 8'hBC;
   localparam logic [7:0] OPC_CMP_IMM = 8'hC9, OPC_CMP_ZP  = 8'hC5, OPC_CMP_ZPX = 8'hD5;
   localparam logic [7:0] OPC_CMP_ABS = 8'hCD, OPC_CMP_ABX = 8'hDD, OPC_CMP_ABY = 8'hD9;
   localparam logic [7:0] OPC_CMP_IZX = 8'hC1, OPC_CMP_IZY = 8'hD1;
   localparam logic [7:0] OPC_CPX_IMM = 8'hE0, OPC_CPX_ZP  = 8'hE4, OPC_CPX_ABS = 8'hEC;
   localparam logic [7:0] OPC_CPY_IMM = 8'hC0, OPC_CPY_ZP  = 8'hC4, OPC_CPY_ABS = 8'hCC;
   localparam logic [7:0] OPC_INX = 8'hE8, OPC_INY = 8'hC8, OPC_DEX = 8'hCA, OPC_DEY = 8'h88;
   localparam logic [7:0] OPC_TAX = 8'hAA, OPC_TAY = 8'hA8, OPC_TXA = 8'h8A, OPC_TYA = 8'h98;
   localparam logic [7:0] OPC_TXS = 8'h9A, OPC_CLD = 8'hD8, OPC_NOP = 8'hEA;
   localparam logic [7:0] OPC_BPL = 8'h10, OPC_BMI = 8'h30, OPC_BVC = 8'h50, OPC_BVS = 8'h70;
   localparam logic [7:0] OPC_BCC = 8'h90, OPC_BCS = 8'hB0, OPC_BNE = 8'hD0, OPC_BEQ = 8'hF0;
   // real 6502 opcodes that this unit does not execute
   localparam logic [7:0] OPC_BRK = 8'h00, OPC_ORA_IMM = 8'h09, OPC_JMP_ABS = 8'h4C;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [7:0]  sp;
      logic [7:0]  status;
      logic        taken;
      logic [15:0] next_pc;
      logic        crossed;
      logic        unsupported;
   } exec_result_type;

   function automatic op_type decode_opcode(logic [7:0] opc);
      case (opc)
         OPC_ADC_IMM, OPC_ADC_ZP, OPC_ADC_ZPX, OPC_ADC_ABS,
         OPC_ADC_ABX, OPC_ADC_ABY, OPC_ADC_IZX, OPC_ADC_IZY: return OP_ADC;
         OPC_ORA_IZX, OPC_ORA_ZP, OPC_ORA_ABS, OPC_ORA_IZY,
         OPC_ORA_ZPX, OPC_ORA_ABY, OPC_ORA_ABX: return OP_ORA;
         OPC_LDA_IMM, OPC_LDA_ZP, OPC_LDA_ZPX, OPC_LDA_ABS,
         OPC_LDA_ABX, OPC_LDA_ABY, OPC_LDA_IZX, OPC_LDA_IZY: return OP_LDA;
         OPC_LDX_IMM, OPC_LDX_ZP, OPC_LDX_ZPY, OPC_LDX_ABS, OPC_LDX_ABY: return OP_LDX;
         OPC_LDY_IMM, OPC_LDY_ZP, OPC_LDY_ZPX, OPC_LDY_ABS, OPC_LDY_ABX: return OP_LDY;
         OPC_CMP_IMM, OPC_CMP_ZP, OPC_CMP_ZPX, OPC_CMP_ABS,
         OPC_CMP_ABX, OPC_CMP_ABY, OPC_CMP_IZX, OPC_CMP_IZY: return OP_CMP;
         OPC_CPX_IMM, OPC_CPX_ZP, OPC_CPX_ABS: return OP_CPX;
         OPC_CPY_IMM, OPC_CPY_ZP, OPC_CPY_ABS: return OP_CPY;
         OPC_INX: return OP_INX;
         OPC_INY: return OP_INY;
         OPC_DEX: return OP_DEX;
         OPC_DEY: return OP_DEY;
         OPC_TAX: return OP_TAX;
         OPC_TAY: return OP_TAY;
         OPC_TXA: return OP_TXA;
         OPC_TYA: return OP_TYA;
         OPC_TXS: return OP_TXS;
         OPC_CLD: return OP_CLD;
         OPC_NOP: return OP_NOP;
         OPC_BPL, OPC_BMI, OPC_BVC, OPC_BVS,
         OPC_BCC, OPC_BCS, OPC_BNE, OPC_BEQ: return OP_BRANCH;
         default: return OP_BAD;
      endcase
   endfunction

   class exec_scoreboard;
      regs_type        regs;
      exec_result_type expected_q[$];
      int unsigned     mismatches;

      function new();
         regs = '0;
         mismatches = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void set_zn(logic [7:0] v);
         regs.status[FLAG_Z] = (v == 8'h00);
         regs.status[FLAG_N] = v[7];
      endfunction

      function void compare_to(logic [7:0] reg_val, logic [7:0] data);
         regs.status[FLAG_C] = (reg_val >= data);
         set_zn(reg_val - data);
      endfunction

      // advance the register file by one instruction and queue the result it gives
      function void note_instruction(logic [7:0] opc, logic [7:0] data, logic [15:0] pc_after);
         exec_result_type res;
         logic [8:0]      sum;
         logic [7:0]      r;
         logic            flag_now;
         res = '0;
         res.next_pc = pc_after;
         case (decode_opcode(opc))
            OP_ADC: begin
               sum = {1'b0, regs.acc} + {1'b0, data} + {8'd0, regs.status[FLAG_C]};
               r = sum[7:0];
               regs.status[FLAG_C] = sum[8];
               regs.status[FLAG_V] = ~(regs.acc[7] ^ data[7]) & (regs.acc[7] ^ r[7]);
               set_zn(r);
               regs.acc = r;
            end
            OP_ORA: begin
               regs.acc = regs.acc | data;
               set_zn(regs.acc);
            end
            OP_LDA: begin regs.acc = data; set_zn(data); end
            OP_LDX: begin regs.x = data; set_zn(data); end
            OP_LDY: begin regs.y = data; set_zn(data); end
            OP_CMP: compare_to(regs.acc, data);
            OP_CPX: compare_to(regs.x, data);
            OP_CPY: compare_to(regs.y, data);
            OP_INX: begin regs.x = regs.x + 8'd1; set_zn(regs.x); end
            OP_INY: begin regs.y = regs.y + 8'd1; set_zn(regs.y); end
            OP_DEX: begin regs.x = regs.x - 8'd1; set_zn(regs.x); end
            OP_DEY: begin regs.y = regs.y - 8'd1; set_zn(regs.y); end
            OP_TAX: begin regs.x = regs.acc; set_zn(regs.x); end
            OP_TAY: begin regs.y = regs.acc; set_zn(regs.y); end
            OP_TXA: begin regs.acc = regs.x; set_zn(regs.acc); end
            OP_TYA: begin regs.acc = regs.y; set_zn(regs.acc); end
            OP_TXS: regs.sp = regs.x;
            OP_CLD: regs.status[FLAG_D] = 1'b0;
            OP_NOP: ;
            OP_BRANCH: begin
               case (opc[7:6])
                  BR_SEL_N: flag_now = regs.status[FLAG_N];
                  BR_SEL_V: flag_now = regs.status[FLAG_V];
                  BR_SEL_C: flag_now = regs.status[FLAG_C];
                  default:  flag_now = regs.status[FLAG_Z];
               endcase
               // bit 5 of the opcode gives the flag value that takes the branch
               if (flag_now == opc[5]) begin
                  res.taken = 1'b1;
                  res.next_pc = pc_after + {{8{data[7]}}, data};
                  res.crossed = (res.next_pc[15:8] != pc_after[15:8]);
               end
            end
            default: res.unsupported = 1'b1;
         endcase
         res.acc = regs.acc;
         res.x = regs.x;
         res.y = regs.y;
         res.sp = regs.sp;
         res.status = regs.status;
         expected_q.push_back(res);
      endfunction

      function void compare_field(string field, logic [15:0] want, logic [15:0] got);
         if (want != got) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(exec_result_type got);
         exec_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t ns: result expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("acc_value", 16'(want.acc), 16'(got.acc));
         compare_field("x_value", 16'(want.x), 16'(got.x));
         compare_field("y_value", 16'(want.y), 16'(got.y));
         compare_field("sp_value", 16'(want.sp), 16'(got.sp));
         compare_field("status_value", 16'(want.status), 16'(got.status));
         compare_field("branch_taken", 16'(want.taken), 16'(got.taken));
         compare_field("next_pc", want.next_pc, got.next_pc);
         compare_field("page_crossed", 16'(want.crossed), 16'(got.crossed));
         compare_field("unsupported", 16'(want.unsupported), 16'(got.unsupported));
      endfunction
   endclass

endpackage

### bench/tb_top.sv
// top level bench for cpu8_execute_unit: clock, reset, instruction sender, result receiver
// directed instruction list first, then random instruction streams with bursty traffic
// depends on cpu8eu_pkg, cpu8eu_check_pkg and the execute unit rtl
module tb_top
   import cpu8eu_pkg::*, cpu8eu_check_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no transfer on either channel before the run is called hung
   localparam int unsigned STALL_LIMIT = 2000;
   // items per random phase, five phases in all
   localparam int unsigned PHASE_ITEMS = 170;
   // length of the deliberate receiver hold-off
   localparam int unsigned HOLD_CYCLES = 80;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_MOSTLY,
      RX_EVERY_THIRD,
      RX_SPARSE
   } rx_style_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_opcode = '0;
   logic [7:0]  req_operand_byte = '0;
   logic [15:0] req_pc_next = '0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_acc_value;
   logic [7:0]  rsp_x_value;
   logic [7:0]  rsp_y_value;
   logic [7:0]  rsp_sp_value;
   logic [7:0]  rsp_status_value;
   logic        rsp_branch_taken;
   logic [15:0] rsp_next_pc;
   logic        rsp_page_crossed;
   logic        rsp_unsupported;

   exec_scoreboard sb = new();

   // opcode pools, filled from the decode table at time zero
   logic [7:0]  plain_ops[$];
   logic [7:0]  branch_ops[$];

   // sender burst shaping
   int unsigned burst_left = 0;
   bit          gaps_on = 1'b1;
   // main flow asks the receiver for one long hold-off
   bit          hold_off_request = 1'b0;
   int unsigned idle_cycles = 0;

   cpu8_execute_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_operand_byte (req_operand_byte),
      .req_pc_next      (req_pc_next),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_acc_value    (rsp_acc_value),
      .rsp_x_value      (rsp_x_value),
      .rsp_y_value      (rsp_y_value),
      .rsp_sp_value     (rsp_sp_value),
      .rsp_status_value (rsp_status_value),
      .rsp_branch_taken (rsp_branch_taken),
      .rsp_next_pc      (rsp_next_pc),
      .rsp_page_crossed (rsp_page_crossed),
      .rsp_unsupported  (rsp_unsupported)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // monitor: both channels are sampled at the edge with their pre-edge values,
   // so the instruction is noted before its result can ever show up
   always @(posedge clock) begin
      exec_result_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_instruction(req_opcode, req_operand_byte, req_pc_next);
         if (rsp_valid && rsp_ready) begin
            got.acc = rsp_acc_value;
            got.x = rsp_x_value;
            got.y = rsp_y_value;
            got.sp = rsp_sp_value;
            got.status = rsp_status_value;
            got.taken = rsp_branch_taken;
            got.next_pc = rsp_next_pc;
            got.crossed = rsp_page_crossed;
            got.unsupported = rsp_unsupported;
            sb.check_result(got);
         end
         // watchdog on the handshakes, not on wall time
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // receiver: switches between stall styles in stretches of random length,
   // one style never stalls; a long hold-off is served on request
   initial begin
      rx_style_type style;
      int unsigned  style_left;
      int unsigned  hold_left;
      int unsigned  phase_count;
      style = RX_ALWAYS;
      style_left = 0;
      hold_left = 0;
      phase_count = 0;
      forever begin
         @(posedge clock);
         phase_count++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style = rx_style_type'($urandom_range(0, 3));
               style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (style)
               RX_ALWAYS:      rsp_ready <= 1'b1;
               RX_MOSTLY:      rsp_ready <= ($urandom_range(0, 99) < 70);
               RX_EVERY_THIRD: rsp_ready <= (phase_count % 3 == 0);
               default:        rsp_ready <= ($urandom_range(0, 99) < 20);
            endcase
         end
      end
   end

   // offer one instruction and hold it until the transfer; the burst counter
   // then decides whether the sender goes quiet for a random gap
   task automatic send_item(input logic [7:0] opc, input logic [7:0] data,
                            input logic [15:0] pc);
      int unsigned gap;
      req_valid <= 1'b1;
      req_opcode <= opc;
      req_operand_byte <= data;
      req_pc_next <= pc;
      do @(posedge clock); while (!req_ready);
      if (burst_left != 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = gaps_on ? $urandom_range(0, 10) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // sender goes quiet until every outstanding result has been checked
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // random instruction: mostly supported opcodes, a good share of branches
   // so the flags get tested, some raw bytes for the unsupported path;
   // operands and pcs lean toward the edges of their ranges
   task automatic pick_instruction(output logic [7:0] opc, output logic [7:0] data,
                                   output logic [15:0] pc);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 12)
         opc = 8'($urandom_range(0, 255));
      else if (roll < 35)
         opc = branch_ops[$urandom_range(0, branch_ops.size() - 1)];
      else
         opc = plain_ops[$urandom_range(0, plain_ops.size() - 1)];
      if ($urandom_range(0, 99) < 30) begin
         case ($urandom_range(0, 4))
            0:       data = 8'h00;
            1:       data = 8'h01;
            2:       data = 8'h7F;
            3:       data = 8'h80;
            default: data = 8'hFF;
         endcase
      end else begin
         data = 8'($urandom_range(0, 255));
      end
      pc = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 9))
         0:       pc[15:8] = 8'hFF;
         1:       pc[15:8] = 8'h00;
         2:       pc[7:0] = {5'h1F, 3'($urandom_range(0, 7))};
         3:       pc[7:0] = {5'h00, 3'($urandom_range(0, 7))};
         default: ;
      endcase
   endtask

   initial begin
      int unsigned phase;
      int unsigned n;
      logic [7:0]  opc;
      logic [7:0]  data;
      logic [15:0] pc;

      for (int code = 0; code < 256; code++) begin
         case (decode_opcode(8'(code)))
            OP_BAD:    ;
            OP_BRANCH: branch_ops.push_back(8'(code));
            default:   plain_ops.push_back(8'(code));
         endcase
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: zero and negative loads, the N flag driving a branch both ways,
      // Z, V and C branches, backward and forward target wrap, page cross,
      // signed overflow, carry out, compares equal / above / below, every
      // transfer and inc/dec wrap, then opcodes outside the table
      send_item(OPC_LDA_IMM, 8'h00, 16'h0000);
      send_item(OPC_LDX_IMM, 8'h80, 16'hFFFF);
      send_item(OPC_BMI,     8'h10, 16'h1234);
      send_item(OPC_BPL,     8'h10, 16'h1234);
      send_item(OPC_LDY_IMM, 8'hFF, 16'h00FF);
      send_item(OPC_INY,     8'h00, 16'h0100);
      send_item(OPC_BEQ,     8'h80, 16'h0005);
      send_item(OPC_DEY,     8'h00, 16'h0006);
      send_item(OPC_LDA_IMM, 8'h7F, 16'h0008);
      send_item(OPC_ADC_IMM, 8'h01, 16'h000A);
      send_item(OPC_BVS,     8'h7F, 16'hFFF0);
      send_item(OPC_ADC_ABS, 8'h80, 16'h0010);
      send_item(OPC_BCS,     8'h02, 16'h10FE);
      send_item(OPC_CMP_IMM, 8'h00, 16'h2000);
      send_item(OPC_CPY_IMM, 8'h00, 16'h2002);
      send_item(OPC_CPX_IMM, 8'hFF, 16'h2004);
      send_item(OPC_TXA,     8'h00, 16'h2005);
      send_item(OPC_TXS,     8'h00, 16'h2006);
      send_item(OPC_TAY,     8'h00, 16'h2007);
      send_item(OPC_TYA,     8'h00, 16'h2008);
      send_item(OPC_TAX,     8'h00, 16'h2009);
      send_item(OPC_DEX,     8'h00, 16'h200A);
      send_item(OPC_INX,     8'h00, 16'h200B);
      send_item(OPC_ORA_ZP,  8'h5A, 16'h200D);
      send_item(OPC_CLD,     8'h00, 16'h200E);
      send_item(OPC_NOP,     8'h00, 16'h200F);
      send_item(OPC_BRK,     8'hFF, 16'h2010);
      send_item(OPC_ORA_IMM, 8'hFF, 16'h2012);
      send_item(OPC_JMP_ABS, 8'hFF, 16'h2015);
      drain_results();

      for (phase = 0; phase < 5; phase++) begin
         // phase 2 opens with gapless traffic against a receiver that holds
         // off, so the unit fills up and has to stall its input
         if (phase == 2) begin
            gaps_on = 1'b0;
            hold_off_request = 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 40)
               gaps_on = 1'b1;
            pick_instruction(opc, data, pc);
            send_item(opc, data, pc);
         end
         // after phases 1 and 3 the sender waits here until every result is back
         if (phase == 1 || phase == 3)
            drain_results();
      end

      drain_results();
      // let anything unexpected still show up before the verdict
      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
